// ===== rtl/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the line pixel stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Default coordinate width of the endpoint fields
  localparam int unsigned COORD_BITS_DFLT = 12;

  // Command codes carried on the mode field
  typedef enum logic {
    MODE_START   = 1'b0,
    MODE_ADVANCE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WALK  = 2'd1,
    PH_EXTRA = 2'd2,
    PH_FINAL = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_AXIS   = 2'd1,
    KIND_XMAJOR = 2'd2,
    KIND_YMAJOR = 2'd3
  } kind_e;

endpackage

// ===== rtl/lps_if.sv =====
// ----------------------------------------------------------------------------
// lps_cmd_if / lps_pix_if
// Valid/ready channels for line commands and emitted pixels.
// ----------------------------------------------------------------------------
interface lps_cmd_if
  import lps_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DFLT
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic        [31:0]           line_color;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, line_color,
                  input ready);
  modport sink   (input valid, mode, x_start, y_start, x_end, y_end, line_color,
                  output ready);
endinterface

interface lps_pix_if
  import lps_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DFLT
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] pixel_x;
  logic signed [COORD_BITS:0] pixel_y;
  logic        [31:0]         pixel_color;
  logic                       last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  output ready);
endinterface

// ===== rtl/line_pixel_stepper.sv =====
// ----------------------------------------------------------------------------
// line_pixel_stepper
// Integer line rasterizer: one command in, at most one pixel out per command.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries commands. mode START latches two endpoints and a color and
//   produces no pixel; it drops any line still in progress. mode ADVANCE
//   produces the next pixel of the current line, or nothing when no line is
//   in progress. The last pixel of a line has last_pixel set.
//   pix_o carries pixels with coordinates one bit wider than the endpoints.
//   Latency: a pixel appears on pix_o the cycle after its ADVANCE transaction.
//   Throughput: one command per clock. The walk state updates in the same
//   cycle as the command, and the single output register is refilled while
//   its content is being taken.
//   Reset clears the walk state to idle and empties the output register.
//   When pix_o stalls with a pixel held, cmd_i.ready drops until the pixel is
//   taken; START commands wait as well.
// ----------------------------------------------------------------------------
module line_pixel_stepper
  import lps_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DFLT
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  lps_cmd_if.sink  cmd_i,
  lps_pix_if.source pix_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned PW = COORD_BITS + 1;
  localparam logic signed [PW-1:0] OneS = PW'(1);

  // Walk state
  phase_e                 phase_q, phase_d;
  kind_e                  kind_q, kind_d;
  logic signed [PW-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CW-1:0]   end_x_q, end_x_d, end_y_q, end_y_d;
  logic        [CW-1:0]   major_q, major_d, minor_q, minor_d;
  logic        [PW-1:0]   rem_q, rem_d;
  logic                   step_down_q, step_down_d;
  logic        [31:0]     color_q, color_d;

  // Output register
  logic                   out_valid_q, out_valid_d;
  logic signed [PW-1:0]   out_x_q, out_x_d, out_y_q, out_y_d;
  logic                   out_last_q, out_last_d;
  logic        [31:0]     out_color_q;
  logic                   load_out;

  logic accept;

  // Start decode
  logic signed [PW-1:0] xs, ys, xe, ye, dxs, dys;
  logic        [CW-1:0] dx, dy;
  logic signed [PW-1:0] sx, sy, sex, sey;
  logic                 swap;

  // Walk step terms
  logic signed [PW-1:0] end_x_ext, end_y_ext;
  logic signed [PW-1:0] adv_x, adv_y, tow_x, tow_y, min_x, min_y;
  logic        [PW-1:0] rem_sum;

  assign cmd_i.ready = !out_valid_q || pix_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign xs  = PW'(cmd_i.x_start);
  assign ys  = PW'(cmd_i.y_start);
  assign xe  = PW'(cmd_i.x_end);
  assign ye  = PW'(cmd_i.y_end);
  assign dxs = xe - xs;
  assign dys = ye - ys;
  assign dx  = dxs[PW-1] ? CW'(-dxs) : dxs[CW-1:0];
  assign dy  = dys[PW-1] ? CW'(-dys) : dys[CW-1:0];

  assign end_x_ext = PW'(end_x_q);
  assign end_y_ext = PW'(end_y_q);
  assign adv_x     = cur_x_q + OneS;
  assign adv_y     = cur_y_q + OneS;
  assign tow_x     = (cur_x_q < end_x_ext) ? cur_x_q + OneS :
                     (cur_x_q > end_x_ext) ? cur_x_q - OneS : cur_x_q;
  assign tow_y     = (cur_y_q < end_y_ext) ? cur_y_q + OneS :
                     (cur_y_q > end_y_ext) ? cur_y_q - OneS : cur_y_q;
  assign min_x     = step_down_q ? cur_x_q - OneS : cur_x_q + OneS;
  assign min_y     = step_down_q ? cur_y_q - OneS : cur_y_q + OneS;
  assign rem_sum   = rem_q + PW'(minor_q);

  always_comb begin
    phase_d     = phase_q;
    kind_d      = kind_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    end_x_d     = end_x_q;
    end_y_d     = end_y_q;
    major_d     = major_q;
    minor_d     = minor_q;
    rem_d       = rem_q;
    step_down_d = step_down_q;
    color_d     = color_q;
    load_out    = 1'b0;
    out_x_d     = cur_x_q;
    out_y_d     = cur_y_q;
    out_last_d  = 1'b0;
    swap        = 1'b0;
    sx          = xs;
    sy          = ys;
    sex         = xe;
    sey         = ye;

    if (accept && cmd_i.mode == MODE_START) begin
      color_d     = cmd_i.line_color;
      rem_d       = '0;
      step_down_d = 1'b0;
      major_d     = '0;
      minor_d     = '0;
      if (xs == xe && ys == ye) begin
        kind_d  = KIND_POINT;
        phase_d = PH_FINAL;
      end else if (xs == xe || ys == ye) begin
        kind_d  = KIND_AXIS;
        phase_d = PH_WALK;
      end else if (dx >= dy) begin
        kind_d  = KIND_XMAJOR;
        swap    = xe < xs;
        major_d = dx;
        minor_d = dy;
        phase_d = PH_WALK;
      end else begin
        kind_d  = KIND_YMAJOR;
        swap    = ye < ys;
        major_d = dy;
        minor_d = dx;
        phase_d = PH_WALK;
      end
      if (swap) begin
        sx  = xe;
        sy  = ye;
        sex = xs;
        sey = ys;
      end
      cur_x_d = sx;
      cur_y_d = sy;
      end_x_d = sex[CW-1:0];
      end_y_d = sey[CW-1:0];
      if (kind_d == KIND_XMAJOR) begin
        step_down_d = sey < sy;
      end else if (kind_d == KIND_YMAJOR) begin
        step_down_d = sex < sx;
      end
    end else if (accept) begin
      unique case (phase_q)
        PH_FINAL: begin
          load_out   = 1'b1;
          out_x_d    = end_x_ext;
          out_y_d    = end_y_ext;
          out_last_d = 1'b1;
          phase_d    = PH_IDLE;
        end
        PH_EXTRA: begin
          load_out = 1'b1;
          phase_d  = PH_WALK;
          if (kind_q == KIND_XMAJOR) begin
            cur_x_d = adv_x;
            if (adv_x > end_x_ext) phase_d = PH_FINAL;
          end else begin
            cur_y_d = adv_y;
            if (adv_y > end_y_ext) phase_d = PH_FINAL;
          end
        end
        PH_WALK: begin
          load_out = 1'b1;
          if (kind_q == KIND_AXIS) begin
            cur_x_d = tow_x;
            cur_y_d = tow_y;
            if (tow_x == end_x_ext && tow_y == end_y_ext) phase_d = PH_FINAL;
          end else if (kind_q == KIND_POINT) begin
            phase_d = PH_FINAL;
          end else if (rem_sum >= PW'(major_q)) begin
            // minor step: extra pixel at the new position next
            rem_d   = rem_sum - PW'(major_q);
            phase_d = PH_EXTRA;
            if (kind_q == KIND_XMAJOR) cur_y_d = min_y;
            else                       cur_x_d = min_x;
          end else begin
            rem_d = rem_sum;
            if (kind_q == KIND_XMAJOR) begin
              cur_x_d = adv_x;
              if (adv_x > end_x_ext) phase_d = PH_FINAL;
            end else begin
              cur_y_d = adv_y;
              if (adv_y > end_y_ext) phase_d = PH_FINAL;
            end
          end
        end
        PH_IDLE: begin
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  assign out_valid_d = load_out ? 1'b1 : (pix_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      kind_q      <= KIND_POINT;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      end_x_q     <= '0;
      end_y_q     <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      rem_q       <= '0;
      step_down_q <= 1'b0;
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      end_x_q     <= end_x_d;
      end_y_q     <= end_y_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      rem_q       <= rem_d;
      step_down_q <= step_down_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_color_q <= color_q;
      out_last_q  <= out_last_d;
    end
  end

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_x     = out_x_q;
  assign pix_o.pixel_y     = out_y_q;
  assign pix_o.pixel_color = out_color_q;
  assign pix_o.last_pixel  = out_last_q;

  // Assertions

  // A start command always leaves a line pending
  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i.mode == MODE_START |=> phase_q == PH_WALK || phase_q == PH_FINAL)
    else $error("start command did not arm a line");

  // The extra minor-step pixel only exists on sloped lines
  a_extra_sloped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_EXTRA |-> kind_q == KIND_XMAJOR || kind_q == KIND_YMAJOR)
    else $error("extra pixel phase on a non-sloped line");

  // An axis line keeps one coordinate on the endpoint while walking
  a_axis_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WALK && kind_q == KIND_AXIS
      |-> cur_x_q == end_x_ext || cur_y_q == end_y_ext)
    else $error("axis line left its axis");

  // Remainder stays below the major delta on sloped lines
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WALK || phase_q == PH_EXTRA)
      && (kind_q == KIND_XMAJOR || kind_q == KIND_YMAJOR)
      |-> rem_q < PW'(major_q))
    else $error("error remainder out of range");

  // A pixel is only produced by an advance command
  a_load_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept) && $past(cmd_i.mode) == MODE_ADVANCE)
    else $error("pixel produced without an advance command");

endmodule
